// ===== sv/vhfc_pkg.sv =====
// vhfc_pkg: shared constants and types for the voxel hidden-face culling block.
// World geometry, command codes, queue word and back-to-front status struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vhfc_pkg;

  localparam int CHUNK_SIZE      = 16;
  localparam int CHUNKS_PER_AXIS = 4;
  localparam int WORLD_SIZE      = CHUNK_SIZE * CHUNKS_PER_AXIS;

  // Coordinate ports are fixed at 6 bits.
  localparam int COORD_W    = 6;
  localparam int COORD_SPAN = 1 << COORD_W;

  // Compare width: holds coord + 1 and WORLD_SIZE.
  localparam int WSZ_W = $clog2(WORLD_SIZE + 1);
  localparam int CMP_W = (WSZ_W > COORD_W + 1) ? WSZ_W : COORD_W + 1;

  // Occupancy store: one row of COORD_SPAN z-bits per (x, y).
  localparam int ROW_W     = COORD_SPAN;
  localparam int ROW_AW    = 2 * COORD_W;
  localparam int ROW_DEPTH = 1 << ROW_AW;

  localparam int FACE_W = 6;
  localparam int NB_N   = 4;   // x/y neighbor rows

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Face bit positions
  localparam int F_PX = 0;
  localparam int F_MX = 1;
  localparam int F_PY = 2;
  localparam int F_MY = 3;
  localparam int F_PZ = 4;
  localparam int F_MZ = 5;

  // Classified word passed from front to back.
  typedef struct packed {
    logic               is_query;
    logic               hit;       // voxel inside world
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               solid;
    logic [FACE_W-1:0]  face_ok;   // neighbor inside world
    logic [FACE_W-1:0]  rd_ok;     // neighbor inside world and addressable
  } cmd_t;

  typedef struct packed {
    logic init_busy;   // clearing pass running
    logic take;        // back pops the queue head this cycle
  } back_stat_t;

  function automatic logic in_world(input logic [COORD_W:0] c);
    in_world = CMP_W'(c) < CMP_W'(WORLD_SIZE);
  endfunction

endpackage

`default_nettype wire

// ===== sv/vhfc_ram.sv =====
// vhfc_ram: generic single-write, single-read RAM with registered read data.
// Standalone, no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module vhfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/vhfc_front.sv =====
// vhfc_front: accepts input words, classifies them against the world bounds
// and holds them in a two-entry queue for the back end. Uses vhfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vhfc_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic                         in_command,
  input  wire logic [vhfc_pkg::COORD_W-1:0] in_coord_x,
  input  wire logic [vhfc_pkg::COORD_W-1:0] in_coord_y,
  input  wire logic [vhfc_pkg::COORD_W-1:0] in_coord_z,
  input  wire logic                         in_solid_in,
  input  wire vhfc_pkg::back_stat_t         stat,
  output logic                              q_vld,
  output vhfc_pkg::cmd_t                    q_cmd
);

  vhfc_pkg::cmd_t cls;
  vhfc_pkg::cmd_t mem_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push_ok;
  logic           px_in, py_in, pz_in;

  // Classification
  always_comb begin
    px_in = vhfc_pkg::in_world({1'b0, in_coord_x} + 7'd1);
    py_in = vhfc_pkg::in_world({1'b0, in_coord_y} + 7'd1);
    pz_in = vhfc_pkg::in_world({1'b0, in_coord_z} + 7'd1);

    cls.is_query = (in_command == vhfc_pkg::CMD_QUERY);
    cls.hit      = vhfc_pkg::in_world({1'b0, in_coord_x})
                 && vhfc_pkg::in_world({1'b0, in_coord_y})
                 && vhfc_pkg::in_world({1'b0, in_coord_z});
    cls.x        = in_coord_x;
    cls.y        = in_coord_y;
    cls.z        = in_coord_z;
    cls.solid    = in_solid_in;

    cls.face_ok             = '0;
    cls.face_ok[vhfc_pkg::F_PX] = px_in;
    cls.face_ok[vhfc_pkg::F_MX] = (in_coord_x != '0);
    cls.face_ok[vhfc_pkg::F_PY] = py_in;
    cls.face_ok[vhfc_pkg::F_MY] = (in_coord_y != '0);
    cls.face_ok[vhfc_pkg::F_PZ] = pz_in;
    cls.face_ok[vhfc_pkg::F_MZ] = (in_coord_z != '0);

    // a plus neighbor past the coordinate span is never stored: reads empty
    cls.rd_ok               = cls.face_ok;
    cls.rd_ok[vhfc_pkg::F_PX] = px_in && (in_coord_x != '1);
    cls.rd_ok[vhfc_pkg::F_PY] = py_in && (in_coord_y != '1);
    cls.rd_ok[vhfc_pkg::F_PZ] = pz_in && (in_coord_z != '1);
  end

  assign full    = (cnt_r == 2'd2) || stat.init_busy;
  assign push_ok = push && !full;
  assign q_vld   = (cnt_r != 2'd0);
  assign q_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push_ok;
    rd_ptr_nxt = rd_ptr_r ^ stat.take;
    cnt_nxt    = cnt_r + {1'b0, push_ok} - {1'b0, stat.take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

`default_nettype wire

// ===== sv/vhfc_back.sv =====
// vhfc_back: runs queued words against the row-organized occupancy RAM
// (read-modify-write or five row reads) and holds the result register.
// Uses vhfc_pkg and vhfc_ram.
`timescale 1ns / 1ps
`default_nettype none

module vhfc_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_vld,
  input  wire vhfc_pkg::cmd_t              q_cmd,
  output vhfc_pkg::back_stat_t             stat,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [vhfc_pkg::FACE_W-1:0]      out_face_mask,
  output logic                             out_solid_out
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_LAST  = 6'b001000,
    S_WRITE = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [vhfc_pkg::ROW_AW-1:0]    clr_r, clr_nxt;
  logic [2:0]                     step_r, step_nxt;
  logic                           cap_vld_r;
  logic [2:0]                     cap_step_r;
  vhfc_pkg::cmd_t                 cmd_r;
  logic [vhfc_pkg::ROW_W-1:0]     row_r;
  logic [vhfc_pkg::NB_N-1:0]      nb_r;
  logic                           out_vld_r, out_vld_nxt;
  logic [vhfc_pkg::FACE_W-1:0]    mask_r;
  logic                           solid_r;

  logic                           ram_we;
  logic [vhfc_pkg::ROW_AW-1:0]    ram_waddr;
  logic [vhfc_pkg::ROW_W-1:0]     ram_wdata;
  logic [vhfc_pkg::ROW_AW-1:0]    ram_raddr;
  logic [vhfc_pkg::ROW_W-1:0]     ram_rdata;

  logic                           load_out;
  logic [vhfc_pkg::FACE_W-1:0]    nb_solid;
  logic [vhfc_pkg::FACE_W-1:0]    mask_c;
  logic                           solid_c;
  logic                           ctr;
  logic [vhfc_pkg::COORD_W-1:0]   zp, zm;

  vhfc_ram #(
    .WIDTH(vhfc_pkg::ROW_W),
    .DEPTH(vhfc_pkg::ROW_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // row address per read step: center, +x, -x, +y, -y
  always_comb begin
    case (step_r)
      3'd1:    ram_raddr = {cmd_r.x + 6'd1, cmd_r.y};
      3'd2:    ram_raddr = {cmd_r.x - 6'd1, cmd_r.y};
      3'd3:    ram_raddr = {cmd_r.x, cmd_r.y + 6'd1};
      3'd4:    ram_raddr = {cmd_r.x, cmd_r.y - 6'd1};
      default: ram_raddr = {cmd_r.x, cmd_r.y};
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {cmd_r.x, cmd_r.y};
    ram_wdata = row_r;
    ram_wdata[cmd_r.z] = cmd_r.solid;
    if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = '0;
    end else if (state_r == S_WRITE) begin
      ram_we = 1'b1;
    end
  end

  // result
  always_comb begin
    zp  = cmd_r.z + 6'd1;
    zm  = cmd_r.z - 6'd1;
    ctr = row_r[cmd_r.z];
    nb_solid                  = '0;
    nb_solid[vhfc_pkg::F_PX]  = nb_r[0];
    nb_solid[vhfc_pkg::F_MX]  = nb_r[1];
    nb_solid[vhfc_pkg::F_PY]  = nb_r[2];
    nb_solid[vhfc_pkg::F_MY]  = nb_r[3];
    nb_solid[vhfc_pkg::F_PZ]  = row_r[zp];
    nb_solid[vhfc_pkg::F_MZ]  = row_r[zm];
    nb_solid = nb_solid & cmd_r.rd_ok;

    mask_c  = '0;
    solid_c = 1'b0;
    if (cmd_r.hit) begin
      if (cmd_r.is_query) begin
        solid_c = ctr;
        if (ctr) begin
          mask_c = cmd_r.face_ok & ~nb_solid;
        end
      end else begin
        solid_c = cmd_r.solid;
      end
    end
  end

  assign load_out = (state_r == S_DONE) && (!out_vld_r || pop);

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    step_nxt       = step_r;
    stat.take      = 1'b0;
    stat.init_busy = (state_r == S_CLEAR);
    out_vld_nxt    = out_vld_r;
    if (pop && out_vld_r) begin
      out_vld_nxt = 1'b0;
    end
    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + vhfc_pkg::ROW_AW'(1);
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        step_nxt = 3'd0;
        if (q_vld) begin
          stat.take = 1'b1;
          state_nxt = q_cmd.hit ? S_READ : S_DONE;
        end
      end
      S_READ: begin
        if (!cmd_r.is_query || step_r == 3'd4) begin
          state_nxt = S_LAST;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      S_LAST: begin
        state_nxt = cmd_r.is_query ? S_DONE : S_WRITE;
      end
      S_WRITE: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (load_out) begin
          out_vld_nxt = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_r     <= '0;
      step_r    <= 3'd0;
      cap_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      step_r    <= step_nxt;
      cap_vld_r <= (state_r == S_READ);
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    cap_step_r <= step_r;
    if (stat.take) begin
      cmd_r <= q_cmd;
    end
    if (cap_vld_r) begin
      case (cap_step_r)
        3'd0:    row_r   <= ram_rdata;
        3'd1:    nb_r[0] <= ram_rdata[cmd_r.z];
        3'd2:    nb_r[1] <= ram_rdata[cmd_r.z];
        3'd3:    nb_r[2] <= ram_rdata[cmd_r.z];
        3'd4:    nb_r[3] <= ram_rdata[cmd_r.z];
        default: row_r   <= ram_rdata;
      endcase
    end
    if (load_out) begin
      mask_r  <= mask_c;
      solid_r <= solid_c;
    end
  end

  assign empty         = !out_vld_r;
  assign out_face_mask = mask_r;
  assign out_solid_out = solid_r;

endmodule

`default_nettype wire

// ===== sv/voxel_hidden_face_culling_top.sv =====
// Voxel hidden-face culling: top level. Front (vhfc_front) -> 2-word queue ->
// back (vhfc_back, occupancy RAM vhfc_ram). Uses vhfc_pkg.
// One result word per input word, in order. A query inside the world takes
// longest, then a write, then a word outside the world; the back finishes each
// word before it takes the next, paced by the single read port of the row
// memory (a query reads five 64-bit rows: center, +x, -x, +y, -y).
// Reset: synchronous active-low; afterward a clearing pass writes all 4096 rows
// with full held high, then the store reads as all empty.
`timescale 1ns / 1ps
`default_nettype none

module voxel_hidden_face_culling_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // input queue side
  input  wire logic                         push,
  output logic                              full,
  input  wire logic                         in_command,
  input  wire logic [vhfc_pkg::COORD_W-1:0] in_coord_x,
  input  wire logic [vhfc_pkg::COORD_W-1:0] in_coord_y,
  input  wire logic [vhfc_pkg::COORD_W-1:0] in_coord_z,
  input  wire logic                         in_solid_in,
  // result queue side
  output logic                              empty,
  input  wire logic                         pop,
  output logic [vhfc_pkg::FACE_W-1:0]       out_face_mask,
  output logic                              out_solid_out
);

  // Front-to-back queue word and back status.
  logic                 q_vld;
  vhfc_pkg::cmd_t       q_cmd;
  vhfc_pkg::back_stat_t stat;

  // Front: bounds checks (world edge, coordinate span) done once per word,
  // so the back only sequences RAM accesses.
  vhfc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_command (in_command),
    .in_coord_x (in_coord_x),
    .in_coord_y (in_coord_y),
    .in_coord_z (in_coord_z),
    .in_solid_in(in_solid_in),
    .stat       (stat),
    .q_vld      (q_vld),
    .q_cmd      (q_cmd)
  );

  // Back: writes do a row read-modify-write; queries read the center row
  // (which also gives the z neighbors) plus four x/y neighbor rows, then
  // build the face mask fresh. The result register frees the back to take
  // the next word as soon as the previous result is popped or the register is empty.
  vhfc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_vld        (q_vld),
    .q_cmd        (q_cmd),
    .stat         (stat),
    .empty        (empty),
    .pop          (pop),
    .out_face_mask(out_face_mask),
    .out_solid_out(out_solid_out)
  );

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// tb: self-checking bench for voxel_hidden_face_culling_top.
// Drives write/query words, predicts occupancy and face masks, checks results in order.
// Depends on vhfc_pkg and the voxel_hidden_face_culling_top RTL.
`timescale 1ns / 1ps

module tb;
  import vhfc_pkg::*;

  localparam int N_RANDOM    = 1580;   // random words after the directed part
  localparam int QUIET_TAIL  = 120;    // last words go out with no idling
  localparam int HOLD_CYCLES = 200;    // long result-side hold-off
  localparam int HOLD_AT     = 400;    // accepted-word count that triggers it
  localparam int DRAIN_WAIT  = 16;     // settle cycles after the last result
  localparam int STALL_LIMIT = 20000;  // longer than the clearing pass plus hold-off
  localparam int STORE_DEPTH = COORD_SPAN * COORD_SPAN * COORD_SPAN;

  // One input word and one result word, at the port widths.
  typedef struct packed {
    logic               cmd;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               solid;
  } voxel_cmd_t;

  typedef struct packed {
    logic [FACE_W-1:0] face;
    logic              solid;
  } face_res_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic               push        = 1'b0;
  logic               full;
  logic               in_command  = CMD_WRITE;
  logic [COORD_W-1:0] in_coord_x  = '0;
  logic [COORD_W-1:0] in_coord_y  = '0;
  logic [COORD_W-1:0] in_coord_z  = '0;
  logic               in_solid_in = 1'b0;
  logic               empty;
  logic               pop         = 1'b0;
  logic [FACE_W-1:0]  out_face_mask;
  logic               out_solid_out;

  voxel_hidden_face_culling_top u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_command    (in_command),
    .in_coord_x    (in_coord_x),
    .in_coord_y    (in_coord_y),
    .in_coord_z    (in_coord_z),
    .in_solid_in   (in_solid_in),
    .empty         (empty),
    .pop           (pop),
    .out_face_mask (out_face_mask),
    .out_solid_out (out_solid_out)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow occupancy store and mask prediction.
  // Indexed x-major like the global coordinate: (x * 64 + y) * 64 + z.
  // Voxels outside the world never get written and read back as empty.
  // ---------------------------------------------------------------------------
  bit occ_shadow [0:STORE_DEPTH-1];

  voxel_cmd_t pending_words [$];     // words still to be offered
  face_res_t  expected_results [$];  // predictions, oldest first

  int n_errors      = 0;
  int n_in_accepted = 0;

  function automatic bit in_bounds(int c);
    return c >= 0 && c < WORLD_SIZE && c < COORD_SPAN;
  endfunction

  function automatic bit voxel_at(int x, int y, int z);
    if (!in_bounds(x) || !in_bounds(y) || !in_bounds(z)) return 1'b0;
    return occ_shadow[(x * COORD_SPAN + y) * COORD_SPAN + z];
  endfunction

  // Applies one word to the shadow store and returns the result it must produce.
  function automatic face_res_t apply_voxel_cmd(voxel_cmd_t c);
    int        x;
    int        y;
    int        z;
    face_res_t r;
    x = c.x;
    y = c.y;
    z = c.z;
    r = '0;
    // Out-of-world address: write dropped, result all zero.
    if (in_bounds(x) && in_bounds(y) && in_bounds(z)) begin
      if (c.cmd == CMD_WRITE) begin
        occ_shadow[(x * COORD_SPAN + y) * COORD_SPAN + z] = c.solid;
        r.solid = c.solid;
      end else begin
        r.solid = voxel_at(x, y, z);
        // Face shows only if the neighbor is inside the world and empty;
        // crossing a chunk seam is just the next global voxel.
        if (r.solid) begin
          if (x + 1 < WORLD_SIZE && !voxel_at(x + 1, y, z)) r.face[F_PX] = 1'b1;
          if (x > 0 && !voxel_at(x - 1, y, z))              r.face[F_MX] = 1'b1;
          if (y + 1 < WORLD_SIZE && !voxel_at(x, y + 1, z)) r.face[F_PY] = 1'b1;
          if (y > 0 && !voxel_at(x, y - 1, z))              r.face[F_MY] = 1'b1;
          if (z + 1 < WORLD_SIZE && !voxel_at(x, y, z + 1)) r.face[F_PZ] = 1'b1;
          if (z > 0 && !voxel_at(x, y, z - 1))              r.face[F_MZ] = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction.
  // ---------------------------------------------------------------------------
  task automatic add_word(logic cmd, int x, int y, int z, logic solid);
    voxel_cmd_t w;
    w.cmd   = cmd;
    w.x     = x[COORD_W-1:0];
    w.y     = y[COORD_W-1:0];
    w.z     = z[COORD_W-1:0];
    w.solid = solid;
    pending_words.push_back(w);
  endtask

  // Cluster anchor: anywhere, near a chunk seam, or hugging an outer face.
  function automatic int pick_anchor();
    int a;
    case ($urandom_range(0, 3))
      0: a = $urandom_range(0, COORD_SPAN - 4);
      1: a = int'($urandom_range(1, CHUNKS_PER_AXIS)) * CHUNK_SIZE - 2;
      2: a = 0;
      default: a = COORD_SPAN - 4;
    endcase
    if (a < 0) a = 0;
    if (a > COORD_SPAN - 4) a = COORD_SPAN - 4;
    return a;
  endfunction

  initial begin
    int         ax;
    int         ay;
    int         az;
    int         roll;
    voxel_cmd_t w;

    // Directed: empty store, world corners, seam neighbors, buried voxel.
    add_word(CMD_QUERY, 0, 0, 0, 1'b0);        // fresh store reads empty
    add_word(CMD_WRITE, 0, 0, 0, 1'b1);
    add_word(CMD_QUERY, 0, 0, 0, 1'b0);        // minus faces at world edge suppressed
    add_word(CMD_WRITE, 63, 63, 63, 1'b1);
    add_word(CMD_QUERY, 63, 63, 63, 1'b1);     // plus faces suppressed, solid_in ignored
    add_word(CMD_WRITE, 15, 20, 20, 1'b1);     // pair straddling x chunk seam
    add_word(CMD_WRITE, 16, 20, 20, 1'b1);
    add_word(CMD_QUERY, 15, 20, 20, 1'b0);
    add_word(CMD_QUERY, 16, 20, 20, 1'b0);
    add_word(CMD_WRITE, 16, 20, 20, 1'b0);     // clearing reopens the seam face
    add_word(CMD_QUERY, 15, 20, 20, 1'b0);
    add_word(CMD_QUERY, 16, 20, 20, 1'b1);     // empty voxel: no mask
    add_word(CMD_WRITE, 32, 32, 32, 1'b1);     // fully buried voxel
    add_word(CMD_WRITE, 33, 32, 32, 1'b1);
    add_word(CMD_WRITE, 31, 32, 32, 1'b1);
    add_word(CMD_WRITE, 32, 33, 32, 1'b1);
    add_word(CMD_WRITE, 32, 31, 32, 1'b1);
    add_word(CMD_WRITE, 32, 32, 33, 1'b1);
    add_word(CMD_QUERY, 32, 32, 32, 1'b0);
    add_word(CMD_WRITE, 32, 32, 31, 1'b1);
    add_word(CMD_QUERY, 32, 32, 32, 1'b0);     // now mask must be zero
    add_word(CMD_WRITE, 0, 0, 0, 1'b0);
    add_word(CMD_QUERY, 0, 0, 0, 1'b1);
    add_word(CMD_WRITE, 47, 48, 31, 1'b0);     // clear on never-set voxel
    add_word(CMD_QUERY, 63, 0, 63, 1'b0);

    // Random: mostly dense clusters so neighbors interact, some edge hits,
    // some fully random noise. Anchor moves every 32 words.
    ax = 0;
    ay = 0;
    az = 0;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 32 == 0) begin
        ax = pick_anchor();
        ay = pick_anchor();
        az = pick_anchor();
      end
      roll = $urandom_range(0, 99);
      w.cmd   = ($urandom_range(0, 99) < 55) ? CMD_WRITE : CMD_QUERY;
      w.solid = ($urandom_range(0, 99) < 65);
      if (roll < 75) begin
        w.x = COORD_W'(ax + $urandom_range(0, 3));
        w.y = COORD_W'(ay + $urandom_range(0, 3));
        w.z = COORD_W'(az + $urandom_range(0, 3));
      end else begin
        w.x = COORD_W'($urandom_range(0, COORD_SPAN - 1));
        w.y = COORD_W'($urandom_range(0, COORD_SPAN - 1));
        w.z = COORD_W'($urandom_range(0, COORD_SPAN - 1));
        if (roll < 88) begin
          // pin one axis to an outer face
          case ($urandom_range(0, 2))
            0: w.x = $urandom_range(0, 1) ? '1 : '0;
            1: w.y = $urandom_range(0, 1) ? '1 : '0;
            default: w.z = $urandom_range(0, 1) ? '1 : '0;
          endcase
        end
      end
      pending_words.push_back(w);
    end

    // Reset once, then let the words drain through.
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender: offers the head of pending_words at the falling edge.
  // Idle bursts are suppressed in every third block of 100 words and in the quiet tail.
  // ---------------------------------------------------------------------------
  int  send_gap = 0;
  bit  send_calm;
  assign send_calm = (pending_words.size() < QUIET_TAIL) ||
                     ((pending_words.size() / 100) % 3 == 0);

  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else if (send_gap > 0) begin
      push     <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_words.size() == 0) begin
      push <= 1'b0;
    end else if (!send_calm && $urandom_range(0, 5) == 0) begin
      push     <= 1'b0;
      send_gap <= $urandom_range(0, 3);
    end else begin
      push        <= 1'b1;
      in_command  <= pending_words[0].cmd;
      in_coord_x  <= pending_words[0].x;
      in_coord_y  <= pending_words[0].y;
      in_coord_z  <= pending_words[0].z;
      in_solid_in <= pending_words[0].solid;
    end
  end

  // Input acceptance: predict at the edge the word is taken.
  always @(posedge clk) begin
    if (rst_n && push && !full) begin
      expected_results.push_back(apply_voxel_cmd(pending_words[0]));
      void'(pending_words.pop_front());
      n_in_accepted <= n_in_accepted + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: pop at the falling edge. One long hold-off once the run is warm,
  // so the block backs up and holds full high while the sender keeps offering.
  // ---------------------------------------------------------------------------
  int pop_gap   = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop       <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_in_accepted >= HOLD_AT) begin
      pop       <= 1'b0;
      hold_left <= HOLD_CYCLES - 1;
      hold_done <= 1'b1;
    end else if (pop_gap > 0) begin
      pop     <= 1'b0;
      pop_gap <= pop_gap - 1;
    end else if (!send_calm && $urandom_range(0, 5) == 0) begin
      pop     <= 1'b0;
      pop_gap <= $urandom_range(0, 3);
    end else begin
      pop <= 1'b1;
    end
  end

  // Result check: each popped word against the oldest prediction.
  always @(posedge clk) begin
    face_res_t exp_w;
    if (rst_n && pop && !empty) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result word face_mask %02h solid_out %0b",
                 $time, out_face_mask, out_solid_out);
        n_errors++;
      end else begin
        exp_w = expected_results.pop_front();
        if (out_face_mask !== exp_w.face) begin
          $display("%0t: face_mask mismatch expected %02h actual %02h",
                   $time, exp_w.face, out_face_mask);
          n_errors++;
        end
        if (out_solid_out !== exp_w.solid) begin
          $display("%0t: solid_out mismatch expected %0b actual %0b",
                   $time, exp_w.solid, out_solid_out);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: cycles in a row with no word moving on either side.
  int stall_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

endmodule
